// ----- sv/bfra_pkg.sv -----
// bfra_pkg: shared constants for the best-fit region allocator
// no dependencies

package bfra_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] TOTAL_SIZE_RESET = 32'd65536;

endpackage

// ----- sv/bfra_table.sv -----
// bfra_table: region table memory, one synchronous read port and one write port
// depends on nothing

module bfra_table #(
  parameter int REGION_CAPACITY = 64,
  parameter int ADDR_WIDTH = 32,
  localparam int IW = $clog2(REGION_CAPACITY),
  localparam int EW = ADDR_WIDTH + 32 + 1 + 32
) (
  input  logic          clk,
  input  logic [IW-1:0] raddr,
  output logic [EW-1:0] rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [EW-1:0] wdata
);

  logic [EW-1:0] mem [REGION_CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/best_fit_region_allocator.sv -----
// Best-fit region allocator. One request at a time on a valid/ready channel; one
// result word per request. An alloc scans the table and, on a split, shifts entries
// up, one read, wait and write per entry; a free scans to the hit, then reads
// neighbours and shifts entries down, one read, wait and write per entry. A clear
// rewrites the table as one free region. The worst case is set by the single table
// memory and its registered read path. The input is taken again once the result word
// has been taken.
// depends on bfra_pkg, bfra_table

module best_fit_region_allocator #(
  parameter int REGION_CAPACITY = 64,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] req_size,
  input  logic signed [31:0] user_tag,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] address,
  output logic [1:0]  status
);

  localparam int IW = $clog2(REGION_CAPACITY);
  localparam int CW = $clog2(REGION_CAPACITY + 1);
  localparam int AW = ADDR_WIDTH;
  localparam int EW = AW + 65;
  localparam logic [CW-1:0] CAP = CW'(REGION_CAPACITY);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [31:0]   size;
    logic          free;
    logic [31:0]   tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_AEVAL, S_UPRD, S_UPWAIT, S_UPWR, S_AFIN,
    S_FSCAN, S_FNEXT, S_FPREV, S_FDECIDE, S_DNRD, S_DNWAIT, S_DNWR, S_DONE
  } state_t;

  state_t state;
  logic [31:0] total_size;
  logic [CW-1:0] count;
  logic [31:0] req, tagr;
  logic [AW-1:0] faddr;
  logic [CW-1:0] idx, ridx;
  logic rvalid, dvalid;
  logic [IW-1:0] raddr, waddr;
  logic we;
  entry_t wdata, rd;
  logic [EW-1:0] rdata;
  logic found;
  logic [31:0] best_loss;
  logic [CW-1:0] best;
  entry_t best_e;
  logic [CW-1:0] move;
  logic [31:0] msize;
  logic [AW-1:0] mbase;
  logic [CW-1:0] hit;

  assign rd = entry_t'(rdata);
  assign in_ready = (state == S_IDLE) && !out_valid;

  bfra_table #(.REGION_CAPACITY(REGION_CAPACITY), .ADDR_WIDTH(ADDR_WIDTH)) u_table (
    .clk(clk), .raddr(raddr), .rdata(rdata), .we(we), .waddr(waddr), .wdata(wdata)
  );

  logic [31:0] loss;
  assign loss = rd.size - req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total_size <= bfra_pkg::TOTAL_SIZE_RESET;
      count <= CW'(1);
      out_valid <= 1'b0;
      we <= 1'b1;
      waddr <= '0;
      wdata <= '{start: '0, size: bfra_pkg::TOTAL_SIZE_RESET, free: 1'b1, tag: '0};
      rvalid <= 1'b0;
      dvalid <= 1'b0;
      raddr <= '0;
    end else begin
      we <= 1'b0;
      rvalid <= 1'b0;
      dvalid <= rvalid;
      if (cfg_we) begin
        total_size <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= req_size;
            tagr <= user_tag;
            faddr <= AW'({32'd0, free_address});
            address <= '0;
            status <= bfra_pkg::ST_OK;
            found <= 1'b0;
            best_loss <= bfra_pkg::INT_MAX;
            idx <= '0;
            raddr <= '0;
            rvalid <= 1'b1;
            ridx <= '0;
            unique case (operation)
              bfra_pkg::OP_ALLOC: state <= S_SCAN;
              bfra_pkg::OP_FREE:  state <= S_FSCAN;
              bfra_pkg::OP_CLEAR: begin
                we <= 1'b1;
                waddr <= '0;
                wdata <= '{start: '0, size: total_size, free: 1'b1, tag: '0};
                count <= CW'(1);
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (idx + CW'(1) < count) begin
            raddr <= IW'(idx + CW'(1));
            rvalid <= 1'b1;
          end
          idx <= idx + CW'(1);
          ridx <= idx;
          if (dvalid && rd.free && req <= rd.size && loss < best_loss) begin
            best_loss <= loss;
            best <= ridx;
            best_e <= rd;
            found <= 1'b1;
          end
          if (!rvalid && idx != '0) begin
            state <= S_AEVAL;
          end
        end
        S_AEVAL: begin
          if (!found) begin
            status <= bfra_pkg::ST_NOSPACE;
            state <= S_DONE;
          end else if (best_loss != '0 && count >= CAP) begin
            status <= bfra_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            address <= 32'(best_e.start);
            if (best_loss == '0) begin
              state <= S_AFIN;
            end else begin
              idx <= count;
              state <= S_UPRD;
            end
          end
        end
        S_UPRD: begin
          if (idx > best + CW'(1)) begin
            raddr <= IW'(idx - CW'(1));
            state <= S_UPWAIT;
          end else begin
            we <= 1'b1;
            waddr <= IW'(best + CW'(1));
            wdata <= '{start: best_e.start + AW'(req), size: best_loss,
                       free: 1'b1, tag: '0};
            count <= count + CW'(1);
            state <= S_AFIN;
          end
        end
        S_UPWAIT: begin
          state <= S_UPWR;
        end
        S_UPWR: begin
          we <= 1'b1;
          waddr <= IW'(idx);
          wdata <= rd;
          idx <= idx - CW'(1);
          state <= S_UPRD;
        end
        S_AFIN: begin
          we <= 1'b1;
          waddr <= IW'(best);
          wdata <= '{start: best_e.start, size: req, free: 1'b0, tag: tagr};
          state <= S_DONE;
        end
        S_FSCAN: begin
          if (dvalid && rd.start == faddr) begin
            if (rd.free) begin
              status <= bfra_pkg::ST_BADFREE;
              state <= S_DONE;
            end else begin
              hit <= ridx;
              move <= '0;
              msize <= rd.size;
              mbase <= rd.start;
              // right neighbour is already in flight, left one is issued here
              rvalid <= (ridx + CW'(1) < count);
              if (ridx != '0) begin
                raddr <= IW'(ridx - CW'(1));
              end
              state <= S_FNEXT;
            end
          end else if (!rvalid && idx != '0) begin
            status <= bfra_pkg::ST_BADFREE;
            state <= S_DONE;
          end else begin
            if (idx + CW'(1) < count) begin
              raddr <= IW'(idx + CW'(1));
              rvalid <= 1'b1;
            end
            idx <= idx + CW'(1);
            ridx <= idx;
          end
        end
        S_FNEXT: begin
          if (rvalid && rd.free) begin
            move <= CW'(1);
            msize <= msize + rd.size;
          end
          rvalid <= (hit != '0);
          state <= S_FPREV;
        end
        S_FPREV: begin
          if (rvalid && rd.free) begin
            move <= move + CW'(1);
            msize <= msize + rd.size;
            mbase <= rd.start;
            hit <= hit - CW'(1);
          end
          state <= S_FDECIDE;
        end
        S_FDECIDE: begin
          we <= 1'b1;
          waddr <= IW'(hit);
          wdata <= '{start: mbase, size: msize, free: 1'b1, tag: '0};
          idx <= hit + CW'(1);
          state <= (move != '0) ? S_DNRD : S_DONE;
        end
        S_DNRD: begin
          if (idx + move < count) begin
            raddr <= IW'(idx + move);
            state <= S_DNWAIT;
          end else begin
            count <= count - move;
            state <= S_DONE;
          end
        end
        S_DNWAIT: begin
          state <= S_DNWR;
        end
        S_DNWR: begin
          we <= 1'b1;
          waddr <= IW'(idx);
          wdata <= rd;
          idx <= idx + CW'(1);
          state <= S_DNRD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bfra_checker.sv -----
// bfra_checker: port-level checks for the best-fit region allocator
// depends on bfra_pkg, bound to best_fit_region_allocator

module bfra_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] address,
  input logic [1:0]  status
);

  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bfra_pkg::ST_OK |-> address == '0)
    else $error("failed request reports an address");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(address) && $stable(status))
    else $error("result word changed while stalled");

  a_accept_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result without processing");

endmodule

bind best_fit_region_allocator bfra_checker u_bfra_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .address(address), .status(status)
);
